@@ src/snrmix_pkg.sv @@
// Shared constants, datapath operation codes and status bundle for the SNR noise mixer.
// No dependencies; every other file takes names from here by scope.
`default_nettype none
package snrmix_pkg;

  localparam int MAX_SAMPLES_LOG2_DEF = 16;
  localparam int GAIN_FRAC_BITS_DEF   = 16;

  localparam int SAMPLE_W   = 16;
  localparam int SNR_W      = 7;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int AMP_W      = 42;
  localparam int CNT_W      = 7;
  localparam int SQRT_STEPS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SNR_DB    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_ADD = 2'd1;

  localparam logic [28:0] AMP_UP_Q28   = 29'd300939535;
  localparam logic [28:0] AMP_DOWN_Q28 = 29'd239243352;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_INT,
    OP_DIV_FRAC,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_SHIFT,
    OP_AMP_INIT,
    OP_AMP,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_C,
    OP_MUL_D,
    OP_FIN,
    OP_SAT,
    OP_MIX_MUL,
    OP_MIX_OUT
  } op_t;

  typedef struct packed {
    logic en_zero;
    logic cnt_last;
    logic cnt_zero;
    logic frac_done;
    logic s_big;
    logic hp_big;
    logic g_big;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/snrmix_if.sv @@
// Valid/ready channel interfaces for the input, result and register write ports.
// Depends on snrmix_pkg for payload widths.
`default_nettype none
interface snrmix_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [snrmix_pkg::SAMPLE_W-1:0] signal_sample;
  logic signed [snrmix_pkg::SAMPLE_W-1:0] noise_sample;
  logic                                last;
  modport source (output valid, mode, signal_sample, noise_sample, last, input ready);
  modport sink   (input valid, mode, signal_sample, noise_sample, last, output ready);
endinterface

interface snrmix_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [snrmix_pkg::SAMPLE_W-1:0] mixed_sample;
  logic                                gain_saturated;
  modport source (output valid, mixed_sample, gain_saturated, input ready);
  modport sink   (input valid, mixed_sample, gain_saturated, output ready);
endinterface

interface snrmix_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [snrmix_pkg::CFG_IDX_W-1:0]      index;
  logic [snrmix_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/snrmix_datapath.sv @@
// Datapath: energy sums, bit-serial divider and square root, gain multiply, mix and output register.
// Depends on snrmix_pkg; driven one operation per cycle by snrmix_ctrl.
`default_nettype none
module snrmix_datapath #(
  parameter int MAX_SAMPLES_LOG2 = snrmix_pkg::MAX_SAMPLES_LOG2_DEF,
  parameter int GAIN_FRAC_BITS   = snrmix_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire snrmix_pkg::op_t                        op,
  output snrmix_pkg::dp_stat_t                        stat,
  input  wire logic signed [snrmix_pkg::SAMPLE_W-1:0] in_sig,
  input  wire logic signed [snrmix_pkg::SAMPLE_W-1:0] in_noi,
  input  wire logic                                   cfg_we,
  input  wire logic [snrmix_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [snrmix_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                        out_valid,
  input  wire logic                                   out_rdy,
  output logic signed [snrmix_pkg::SAMPLE_W-1:0]      out_mixed,
  output logic                                        out_flag
);

  localparam int EW    = MAX_SAMPLES_LOG2 + 31;
  localparam int F2    = 2 * GAIN_FRAC_BITS;
  localparam int BW    = $clog2(F2 + 1);
  localparam int MPW   = 17 + snrmix_pkg::GAIN_W;
  localparam logic [BW-1:0] FRAC2 = BW'(F2);
  localparam logic [EW-1:0] EMAX  = {EW{1'b1}};

  logic signed [snrmix_pkg::SAMPLE_W-1:0] sig_r, noi_r;
  logic [snrmix_pkg::SNR_W-1:0]  snr_r;
  logic                          plain_r;
  logic [EW-1:0]                 es_r, en_r;
  logic [snrmix_pkg::GAIN_W-1:0] gain_r;
  logic                          gflag_r;
  logic [EW:0]                   rem_r;
  logic [63:0]                   q_r, v_r, rt_r, bit_r, s_r, acc_r;
  logic [BW-1:0]                 b_r;
  logic [snrmix_pkg::CNT_W-1:0]  cnt_r;
  logic [snrmix_pkg::AMP_W-1:0]  p_r;
  logic [MPW-1:0]                mprod_r;
  logic                          out_valid_r;
  logic signed [snrmix_pkg::SAMPLE_W-1:0] out_mixed_r;
  logic                          out_flag_r;

  logic [16:0]  mag_s, mag_n;
  logic [33:0]  sq_s, sq_n;
  logic [EW:0]  sum_s, sum_n;
  logic [EW-1:0] es_acc, en_acc;
  logic         rem_in, div_ge;
  logic [EW:0]  rem_sh, rem_new;
  logic [63:0]  trial;
  logic         sq_ge;
  logic [BW-1:0] kk;
  logic [63:0]  s_sh;
  logic [28:0]  amp_c;
  logic [38:0]  amp_hp;
  logic [60:0]  amp_lp;
  logic [63:0]  amp_sum;
  logic [6:0]   snr_abs;
  logic [21:0]  ma, mb;
  logic [43:0]  mprod;
  logic [MPW-1:0] mix_prod, mix_m;
  logic signed [snrmix_pkg::SAMPLE_W-1:0] prod16;

  always_comb begin
    mag_s = sig_r[15] ? (17'd0 - {sig_r[15], sig_r}) : {sig_r[15], sig_r};
    mag_n = noi_r[15] ? (17'd0 - {noi_r[15], noi_r}) : {noi_r[15], noi_r};
    sq_s  = mag_s * mag_s;
    sq_n  = mag_n * mag_n;
    sum_s = {1'b0, es_r} + (EW+1)'(sq_s);
    sum_n = {1'b0, en_r} + (EW+1)'(sq_n);
    es_acc = sum_s[EW] ? EMAX : sum_s[EW-1:0];
    en_acc = sum_n[EW] ? EMAX : sum_n[EW-1:0];

    rem_in  = (op == snrmix_pkg::OP_DIV_INT) ? es_r[EW-1] : 1'b0;
    rem_sh  = {rem_r[EW-1:0], rem_in};
    div_ge  = rem_sh >= {1'b0, en_r};
    rem_new = div_ge ? (rem_sh - {1'b0, en_r}) : rem_sh;

    trial = rt_r + bit_r;
    sq_ge = v_r >= trial;
    kk    = (FRAC2 - b_r) >> 1;
    s_sh  = {32'd0, rt_r[31:0]} << kk;

    snr_abs = snr_r[6] ? (7'd0 - snr_r) : snr_r;
    amp_c   = snr_r[6] ? snrmix_pkg::AMP_UP_Q28 : snrmix_pkg::AMP_DOWN_Q28;
    amp_hp  = p_r[41:32] * amp_c;
    amp_lp  = p_r[31:0] * amp_c;
    amp_sum = (64'(amp_hp) << 4) + ((64'(amp_lp) + 64'h0000_0000_0800_0000) >> 28);

    ma = (op == snrmix_pkg::OP_MUL_B || op == snrmix_pkg::OP_MUL_D) ?
         {1'b0, s_r[42:22]} : s_r[21:0];
    mb = (op == snrmix_pkg::OP_MUL_A || op == snrmix_pkg::OP_MUL_B) ?
         p_r[41:20] : {2'b00, p_r[19:0]};
    mprod = ma * mb;

    mix_prod = mag_n * gain_r;
    mix_m    = mprod_r >> GAIN_FRAC_BITS;
    if (plain_r) begin
      prod16 = noi_r;
    end else if (noi_r[15]) begin
      prod16 = (mix_m > MPW'(32768)) ? 16'sh8000 : $signed(16'd0 - mix_m[15:0]);
    end else begin
      prod16 = (mix_m > MPW'(32767)) ? 16'sh7FFF : $signed(mix_m[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snr_r       <= '0;
      plain_r     <= 1'b0;
      es_r        <= '0;
      en_r        <= '0;
      gain_r      <= '0;
      gflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          snrmix_pkg::REG_SNR_DB:    snr_r   <= cfg_wdata;
          snrmix_pkg::REG_PLAIN_ADD: plain_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (op == snrmix_pkg::OP_MIX_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_rdy) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        snrmix_pkg::OP_ACC: begin
          es_r <= es_acc;
          en_r <= en_acc;
        end
        snrmix_pkg::OP_DIV_INT: es_r <= {es_r[EW-2:0], 1'b0};
        snrmix_pkg::OP_FIN: begin
          gain_r  <= acc_r[61:30];
          gflag_r <= 1'b0;
          es_r    <= '0;
          en_r    <= '0;
        end
        snrmix_pkg::OP_SAT: begin
          gain_r  <= '1;
          gflag_r <= 1'b1;
          es_r    <= '0;
          en_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      snrmix_pkg::OP_LOAD: begin
        sig_r <= in_sig;
        noi_r <= in_noi;
      end
      snrmix_pkg::OP_DIV_INIT: begin
        q_r   <= '0;
        rem_r <= '0;
        b_r   <= '0;
        cnt_r <= snrmix_pkg::CNT_W'(EW);
      end
      snrmix_pkg::OP_DIV_INT: begin
        rem_r <= rem_new;
        q_r   <= {q_r[62:0], div_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      snrmix_pkg::OP_DIV_FRAC: begin
        rem_r <= rem_new;
        q_r   <= {q_r[62:0], div_ge};
        b_r   <= b_r + 1'b1;
      end
      snrmix_pkg::OP_SQRT_INIT: begin
        v_r   <= q_r;
        rt_r  <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= snrmix_pkg::CNT_W'(snrmix_pkg::SQRT_STEPS);
      end
      snrmix_pkg::OP_SQRT: begin
        if (sq_ge) begin
          v_r  <= v_r - trial;
          rt_r <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      snrmix_pkg::OP_SHIFT: s_r <= s_sh;
      snrmix_pkg::OP_AMP_INIT: begin
        p_r   <= snrmix_pkg::AMP_W'(64'd1 << 30);
        cnt_r <= snrmix_pkg::CNT_W'(snr_abs);
      end
      snrmix_pkg::OP_AMP: begin
        p_r   <= amp_sum[snrmix_pkg::AMP_W-1:0];
        cnt_r <= cnt_r - 1'b1;
      end
      snrmix_pkg::OP_MUL_A: acc_r <= 64'(mprod);
      snrmix_pkg::OP_MUL_B: acc_r <= acc_r + (64'(mprod) << 22);
      snrmix_pkg::OP_MUL_C: acc_r <= (acc_r << 20) + 64'(mprod);
      snrmix_pkg::OP_MUL_D: acc_r <= acc_r + (64'(mprod) << 22);
      snrmix_pkg::OP_MIX_MUL: mprod_r <= mix_prod;
      snrmix_pkg::OP_MIX_OUT: begin
        out_mixed_r <= sig_r + prod16;
        out_flag_r  <= plain_r ? 1'b0 : gflag_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.en_zero   = en_r == '0;
    stat.cnt_last  = cnt_r == snrmix_pkg::CNT_W'(1);
    stat.cnt_zero  = cnt_r == '0;
    stat.frac_done = !b_r[0] && !((b_r < FRAC2) && (q_r[63:61] == 3'd0));
    stat.s_big     = s_r[63:43] != '0;
    stat.hp_big    = acc_r[63:42] != '0;
    stat.g_big     = acc_r[63:62] != 2'd0;
    stat.out_free  = !out_valid_r || out_rdy;
  end

  assign out_valid = out_valid_r;
  assign out_mixed = out_mixed_r;
  assign out_flag  = out_flag_r;

endmodule
`default_nettype wire

@@ src/snrmix_ctrl.sv @@
// Controller: one-hot sequencer that accepts items and steps the datapath through
// accumulate, divide, square root, amplitude, multiply and mix phases. Depends on snrmix_pkg.
`default_nettype none
module snrmix_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_mode,
  input  wire logic                 in_last,
  output logic                      in_rdy,
  input  wire snrmix_pkg::dp_stat_t stat,
  output snrmix_pkg::op_t           op
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_MEAS = 16'h0002,
    S_ZCHK = 16'h0004,
    S_DIVI = 16'h0008,
    S_DIVF = 16'h0010,
    S_SQRT = 16'h0020,
    S_SHFT = 16'h0040,
    S_SCHK = 16'h0080,
    S_AMP  = 16'h0100,
    S_MULB = 16'h0200,
    S_CHKH = 16'h0400,
    S_MULD = 16'h0800,
    S_FIN  = 16'h1000,
    S_MIXP = 16'h2000,
    S_MIXO = 16'h4000,
    S_SQI  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    op        = snrmix_pkg::OP_NONE;
    in_rdy    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_valid) begin
          op        = snrmix_pkg::OP_LOAD;
          last_nxt  = in_last;
          state_nxt = in_mode ? S_MIXP : S_MEAS;
        end
      end
      S_MEAS: begin
        op        = snrmix_pkg::OP_ACC;
        state_nxt = last_r ? S_ZCHK : S_IDLE;
      end
      S_ZCHK: begin
        if (stat.en_zero) begin
          op        = snrmix_pkg::OP_SAT;
          state_nxt = S_IDLE;
        end else begin
          op        = snrmix_pkg::OP_DIV_INIT;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        op = snrmix_pkg::OP_DIV_INT;
        if (stat.cnt_last) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        if (stat.frac_done) begin
          state_nxt = S_SQI;
        end else begin
          op = snrmix_pkg::OP_DIV_FRAC;
        end
      end
      S_SQI: begin
        op        = snrmix_pkg::OP_SQRT_INIT;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        op = snrmix_pkg::OP_SQRT;
        if (stat.cnt_last) begin
          state_nxt = S_SHFT;
        end
      end
      S_SHFT: begin
        op        = snrmix_pkg::OP_SHIFT;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.s_big) begin
          op        = snrmix_pkg::OP_SAT;
          state_nxt = S_IDLE;
        end else begin
          op        = snrmix_pkg::OP_AMP_INIT;
          state_nxt = S_AMP;
        end
      end
      S_AMP: begin
        if (stat.cnt_zero) begin
          op        = snrmix_pkg::OP_MUL_A;
          state_nxt = S_MULB;
        end else begin
          op = snrmix_pkg::OP_AMP;
        end
      end
      S_MULB: begin
        op        = snrmix_pkg::OP_MUL_B;
        state_nxt = S_CHKH;
      end
      S_CHKH: begin
        if (stat.hp_big) begin
          op        = snrmix_pkg::OP_SAT;
          state_nxt = S_IDLE;
        end else begin
          op        = snrmix_pkg::OP_MUL_C;
          state_nxt = S_MULD;
        end
      end
      S_MULD: begin
        op        = snrmix_pkg::OP_MUL_D;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        op        = stat.g_big ? snrmix_pkg::OP_SAT : snrmix_pkg::OP_FIN;
        state_nxt = S_IDLE;
      end
      S_MIXP: begin
        op        = snrmix_pkg::OP_MIX_MUL;
        state_nxt = S_MIXO;
      end
      S_MIXO: begin
        if (stat.out_free) begin
          op        = snrmix_pkg::OP_MIX_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/snr_noise_mixer_top.sv @@
// Top level of the SNR noise mixer: joins controller and datapath to the channel interfaces.
// Depends on snrmix_pkg, snrmix_if, snrmix_ctrl and snrmix_datapath.
//
// One item is handled at a time. A measure item is accepted and accumulated, and a mix item
// is accepted, multiplied and written to the output register; a finished result waits in the
// output register while the next item is taken. The last measure item also runs the gain
// computation: the one-bit-per-cycle restoring divider, the 32-step square root and one
// amplitude step per dB. Registers should be written with cfg_ch only while the block is idle;
// the block itself does not enforce this. cfg_ch is always ready.
`default_nettype none
module snr_noise_mixer_top #(
  parameter int MAX_SAMPLES_LOG2 = snrmix_pkg::MAX_SAMPLES_LOG2_DEF,
  parameter int GAIN_FRAC_BITS   = snrmix_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  snrmix_in_if.sink     in_ch,
  snrmix_out_if.source  out_ch,
  snrmix_cfg_if.sink    cfg_ch
);

  snrmix_pkg::op_t      op;
  snrmix_pkg::dp_stat_t stat;
  logic                 in_rdy;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  snrmix_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_last  (in_ch.last),
    .in_rdy   (in_rdy),
    .stat     (stat),
    .op       (op)
  );

  snrmix_datapath #(
    .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_sig    (in_ch.signal_sample),
    .in_noi    (in_ch.noise_sample),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.data),
    .out_valid (out_ch.valid),
    .out_rdy   (out_ch.ready),
    .out_mixed (out_ch.mixed_sample),
    .out_flag  (out_ch.gain_saturated)
  );

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (op == snrmix_pkg::OP_LOAD))
    else $error("accepted beat without datapath load");

  a_out_after_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (op == snrmix_pkg::OP_MIX_OUT) |=> out_ch.valid)
    else $error("mix result not presented");

  a_out_only_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(op == snrmix_pkg::OP_MIX_OUT))
    else $error("result beat without mix operation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (op == snrmix_pkg::OP_MIX_OUT) |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
